FILE: rtl/nlqm_pkg.sv
// Package for the node liveness monitor: payload types, codes and shared widths.
`timescale 1ns / 1ps
package nlqm_pkg;

    // Default sizing
    localparam int MAX_NODES_DEF = 16;
    localparam int AGE_BITS_DEF  = 16;

    // Widths that cover the largest supported group (64 members)
    localparam int GRP_W  = 7;   // member count 0..64
    localparam int LIDX_W = 6;   // member index 0..63

    // Item kinds
    localparam logic [1:0] FUNC_HEARTBEAT = 2'd0;
    localparam logic [1:0] FUNC_TICK      = 2'd1;
    localparam logic [1:0] FUNC_EVALUATE  = 2'd2;
    localparam logic [1:0] FUNC_FORGET    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_NODE_COUNT   = 3'd0;
    localparam logic [2:0] REG_SELF_NODE    = 3'd1;
    localparam logic [2:0] REG_LIVE_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_SILENT_LIMIT = 3'd3;
    localparam logic [2:0] REG_ARB_ENABLE   = 3'd4;

    // Input item
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  node;
        logic [15:0] global_set;
    } t_req;

    // Result item
    typedef struct packed {
        logic [15:0] live_mask;
        logic [15:0] ping_mask;
        logic        quorum;
        logic        is_leader;
        logic [3:0]  leader_index;
        logic        send_view;
        logic        deliver_view;
    } t_res;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic             hb;        // heartbeat accepted this cycle
        logic             tick;      // tick accepted this cycle
        logic             fgt;       // forget accepted this cycle
        logic [3:0]       node;      // member addressed by heartbeat/forget
        logic             eval;      // request in flight is an evaluate
        logic [GRP_W-1:0] n;         // effective group size
        logic [3:0]       self_node;
        logic [15:0]      live_timeout;
        logic [15:0]      silent_limit;
    } t_cell_ctrl;

    // Token handed from cell to cell along the chain
    typedef struct packed {
        logic              valid;
        logic [GRP_W-1:0]  count;    // live members seen so far
        logic              found;    // leader already chosen
        logic [LIDX_W-1:0] leader;
        logic              gdiff;    // global view differs from liveness
        logic              ldiff;    // local view differs from liveness
    } t_tok;

endpackage

FILE: rtl/nlqm_cell.sv
// One member cell: age and heard state, local view bit, and one step of the sweep.
`timescale 1ns / 1ps
module nlqm_cell
    import nlqm_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_gbit,
    input  t_tok       i_tok,
    output t_tok       o_tok,
    output logic       o_live_bit,
    output logic       o_ping_bit
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0] r_age;
    logic                r_heard;
    logic                r_lv;
    t_tok                r_tok;
    t_tok                n_tok;

    logic in_group;
    logic is_self;
    logic sel;
    logic live;
    logic silent;

    // Membership and liveness of this member
    assign in_group = 32'(i_ctrl.n) > IDX;
    assign is_self  = 32'(i_ctrl.self_node) == IDX;
    assign sel      = in_group && (32'(i_ctrl.node) == IDX);
    assign live     = is_self || (r_heard && (32'(r_age) < 32'(i_ctrl.live_timeout)));
    assign silent   = !r_heard || (32'(r_age) > 32'(i_ctrl.silent_limit));

    assign o_live_bit = in_group && live;
    assign o_ping_bit = in_group && !is_self && silent;

    // Member state update on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age   <= '0;
            r_heard <= 1'b0;
        end else if (i_ctrl.hb && sel) begin
            r_age   <= '0;
            r_heard <= 1'b1;
        end else if (i_ctrl.fgt && sel) begin
            r_age   <= '0;
            r_heard <= 1'b0;
        end else if (i_ctrl.tick && (r_age != AGE_MAX)) begin
            r_age   <= r_age + 1'b1;
        end
    end

    // Sweep step: fold this member into the token
    always_comb begin
        n_tok = i_tok;
        if (in_group) begin
            n_tok.count = i_tok.count + GRP_W'(live);
            if (!i_tok.found && !silent && i_gbit) begin
                n_tok.found  = 1'b1;
                n_tok.leader = LIDX_W'(IDX);
            end
            n_tok.gdiff = i_tok.gdiff | (i_gbit != live);
            n_tok.ldiff = i_tok.ldiff | (r_lv != live);
        end
    end

    // Token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

    // Local view bit follows liveness on an evaluate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (i_tok.valid && i_ctrl.eval && in_group) begin
            r_lv <= live;
        end
    end

endmodule

FILE: rtl/node_liveness_quorum_monitor.sv
// Top level of the node liveness and majority quorum monitor.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Heartbeat, tick and
// forget update the member cells at that edge; a token then walks the row of
// MAX_NODES cells, one cell per cycle, gathering the live count, the leader
// and the view differences. The result appears on o_res with o_res_valid for
// one cycle and must be taken then: there is no back-pressure. busy falls
// together with the result, so a new request can be taken while the result is
// shown, but none while a token is still in the row. Configuration writes are
// always ready and must only be issued while busy is low.
module node_liveness_quorum_monitor
    import nlqm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int AGE_BITS  = AGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [4:0]  r_node_count;
    logic [3:0]  r_self_node;
    logic [15:0] r_live_timeout;
    logic [15:0] r_silent_limit;
    logic        r_arb_en;

    logic        r_busy;
    logic        r_inject;
    logic        r_eval;
    logic [15:0] r_gset;
    logic        r_gpend;
    logic        r_lpend;
    logic        r_res_valid;
    t_res        r_res;

    logic             accept;
    logic [GRP_W-1:0] n_grp;
    t_cell_ctrl       ctrl;
    t_tok             chain [MAX_NODES+1];
    logic [MAX_NODES-1:0] live_vec;
    logic [MAX_NODES-1:0] ping_vec;
    logic [MAX_NODES-1:0] gbit_vec;
    t_tok             tail;

    logic        quorum;
    logic        leader_me;
    logic        gpend;
    logic        send;
    logic        lpend;
    logic [15:0] live_mask;
    logic [15:0] ping_mask;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count   <= '0;
            r_self_node    <= '0;
            r_live_timeout <= 16'd5;
            r_silent_limit <= 16'd4;
            r_arb_en       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NODE_COUNT:   r_node_count   <= i_cfg_data[4:0];
                REG_SELF_NODE:    r_self_node    <= i_cfg_data[3:0];
                REG_LIVE_TIMEOUT: r_live_timeout <= i_cfg_data;
                REG_SILENT_LIMIT: r_silent_limit <= i_cfg_data;
                REG_ARB_ENABLE:   r_arb_en       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective group size
    assign n_grp = (32'(r_node_count) < MAX_NODES) ? GRP_W'(r_node_count)
                                                    : GRP_W'(MAX_NODES);

    // Broadcast control to the cells
    always_comb begin
        ctrl.hb           = accept && (i_req.func == FUNC_HEARTBEAT);
        ctrl.tick         = accept && (i_req.func == FUNC_TICK);
        ctrl.fgt          = accept && (i_req.func == FUNC_FORGET);
        ctrl.node         = i_req.node;
        ctrl.eval         = r_eval;
        ctrl.n            = n_grp;
        ctrl.self_node    = r_self_node;
        ctrl.live_timeout = r_live_timeout;
        ctrl.silent_limit = r_silent_limit;
    end

    // Request capture and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_inject <= 1'b0;
        end else begin
            r_inject <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eval <= (i_req.func == FUNC_EVALUATE);
            r_gset <= i_req.global_set;
        end
    end

    // Token entering the first cell
    always_comb begin
        chain[0]        = '0;
        chain[0].valid  = r_inject;
    end

    // Row of member cells
    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        if (g < 16) begin : g_gb
            assign gbit_vec[g] = r_gset[g];
        end else begin : g_gz
            assign gbit_vec[g] = 1'b0;
        end

        nlqm_cell #(
            .IDX      (g),
            .AGE_BITS (AGE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_gbit     (gbit_vec[g]),
            .i_tok      (chain[g]),
            .o_tok      (chain[g+1]),
            .o_live_bit (live_vec[g]),
            .o_ping_bit (ping_vec[g])
        );
    end

    assign tail = chain[MAX_NODES];

    // Masks narrowed to the result width
    for (genvar m = 0; m < 16; m++) begin : g_mask
        if (m < MAX_NODES) begin : g_on
            assign live_mask[m] = live_vec[m];
            assign ping_mask[m] = ping_vec[m];
        end else begin : g_off
            assign live_mask[m] = 1'b0;
            assign ping_mask[m] = 1'b0;
        end
    end

    // Final quorum, leader and view decisions
    assign quorum    = (n_grp != '0) &&
                       ((tail.count > (n_grp >> 1)) ||
                        (r_arb_en && (n_grp == GRP_W'(2))));
    assign leader_me = (tail.found ? tail.leader : '0) == LIDX_W'(r_self_node);
    assign gpend     = r_gpend || tail.gdiff;
    assign send      = r_eval && gpend && leader_me && quorum;
    assign lpend     = r_lpend || tail.ldiff;

    // Pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpend <= 1'b1;
            r_lpend <= 1'b1;
        end else if (tail.valid && r_eval) begin
            r_gpend <= gpend && !send;
            r_lpend <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            r_res.live_mask    <= live_mask;
            r_res.ping_mask    <= ping_mask;
            r_res.quorum       <= quorum;
            r_res.is_leader    <= leader_me;
            r_res.leader_index <= tail.found ? tail.leader[3:0] : 4'd0;
            r_res.send_view    <= send;
            r_res.deliver_view <= r_eval && lpend;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the node liveness and majority quorum monitor.
`timescale 1ns / 1ps
module tb_top;
    import nlqm_pkg::*;

    localparam int            CYCLE_LIMIT = 4_000_000;
    localparam int            DRAIN_WAIT  = MAX_NODES_DEF + 6;
    localparam int            MAX_REPORTS = 100;
    localparam logic [AGE_BITS_DEF-1:0] AGE_SAT = '1;

    // One queued action for the driver: a request or a register write
    typedef struct {
        bit          is_cfg;
        t_req        req;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        int          idle_pct;
    } t_job;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_req        i_req       = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        busy;
    logic        o_res_valid;
    t_res        o_res;
    logic        o_cfg_ready;

    node_liveness_quorum_monitor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of member state and registers
    logic [AGE_BITS_DEF-1:0] age_cnt [MAX_NODES_DEF];
    logic        heard [MAX_NODES_DEF];
    logic [15:0] view_local;
    logic        pend_global;
    logic        pend_local;
    logic [4:0]  cfg_count;
    logic [3:0]  cfg_self;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_silent;
    logic        cfg_arb;

    t_job  job_queue [$];
    t_res  expected_res [$];
    t_job  cur_job;
    bit    have_job    = 1'b0;
    bit    rst_done    = 1'b0;
    bit    req_taken   = 1'b0;
    bit    cfg_taken   = 1'b0;
    int    err_count   = 0;
    int    cycle_count = 0;
    int    phase_idle  = 0;
    int    gen_count   = 0;
    int    gen_self    = 0;

    task automatic flag_error(string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void clear_state();
        for (int i = 0; i < MAX_NODES_DEF; i++) begin
            age_cnt[i] = '0;
            heard[i]   = 1'b0;
        end
        view_local  = '0;
        pend_global = 1'b1;
        pend_local  = 1'b1;
        cfg_count   = 5'd0;
        cfg_self    = 4'd0;
        cfg_timeout = 16'd5;
        cfg_silent  = 16'd4;
        cfg_arb     = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_NODE_COUNT:   cfg_count   = data[4:0];
            REG_SELF_NODE:    cfg_self    = data[3:0];
            REG_LIVE_TIMEOUT: cfg_timeout = data;
            REG_SILENT_LIMIT: cfg_silent  = data;
            REG_ARB_ENABLE:   cfg_arb     = data[0];
            default: ;
        endcase
    endfunction

    // Update member state for one request and work out its result
    function automatic t_res liveness_step(t_req rq);
        t_res        res;
        int          n;
        int          cnt;
        logic [15:0] live;
        logic [15:0] ping;
        logic [3:0]  lead;
        bit          found;
        bit          quo;
        bit          me;
        bit          live_i;
        bit          silent_i;
        res   = '0;
        live  = '0;
        ping  = '0;
        cnt   = 0;
        lead  = '0;
        found = 1'b0;
        n = (cfg_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(cfg_count);

        case (rq.func)
            FUNC_HEARTBEAT: begin
                if (rq.node < n) begin
                    age_cnt[rq.node] = '0;
                    heard[rq.node]   = 1'b1;
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < MAX_NODES_DEF; i++)
                    if (age_cnt[i] != AGE_SAT)
                        age_cnt[i] = age_cnt[i] + 1'b1;
            end
            FUNC_FORGET: begin
                if (rq.node < n) begin
                    age_cnt[rq.node] = '0;
                    heard[rq.node]   = 1'b0;
                end
            end
            default: ;
        endcase

        // Liveness, silence and leader over the group
        for (int i = 0; i < n; i++) begin
            silent_i = !heard[i] || (age_cnt[i] > cfg_silent);
            live_i   = (i == cfg_self) || (heard[i] && age_cnt[i] < cfg_timeout);
            if (live_i) begin
                live[i] = 1'b1;
                cnt++;
            end
            if (i != cfg_self && silent_i)
                ping[i] = 1'b1;
            if (!found && !silent_i && rq.global_set[i]) begin
                found = 1'b1;
                lead  = 4'(i);
            end
        end
        quo = (n > 0) && ((cnt > n / 2) || (cfg_arb && n == 2));
        me  = (lead == cfg_self);

        // View comparison and sticky send/deliver flags
        if (rq.func == FUNC_EVALUATE) begin
            for (int i = 0; i < n; i++)
                if (rq.global_set[i] != live[i])
                    pend_global = 1'b1;
            if (pend_global && me && quo) begin
                res.send_view = 1'b1;
                pend_global   = 1'b0;
            end
            for (int i = 0; i < n; i++)
                if (view_local[i] != live[i]) begin
                    view_local[i] = live[i];
                    pend_local    = 1'b1;
                end
            if (pend_local) begin
                res.deliver_view = 1'b1;
                pend_local       = 1'b0;
            end
        end

        res.live_mask    = live;
        res.ping_mask    = ping;
        res.quorum       = quo;
        res.is_leader    = me;
        res.leader_index = lead;
        return res;
    endfunction

    task automatic add_req(logic [1:0] fn, logic [3:0] nd, logic [15:0] gs);
        t_job j;
        j.is_cfg   = 1'b0;
        j.req.func = fn;
        j.req.node = nd;
        j.req.global_set = gs;
        j.reg_idx  = '0;
        j.reg_data = '0;
        j.idle_pct = phase_idle;
        job_queue.push_back(j);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [15:0] data);
        t_job j;
        j.is_cfg   = 1'b1;
        j.req      = '0;
        j.reg_idx  = idx;
        j.reg_data = data;
        j.idle_pct = 0;
        job_queue.push_back(j);
    endtask

    task automatic add_setting(int cnt, int self_idx, int tmo, int sil, bit arb);
        add_cfg(REG_NODE_COUNT, 16'(cnt));
        add_cfg(REG_SELF_NODE, 16'(self_idx));
        add_cfg(REG_LIVE_TIMEOUT, 16'(tmo));
        add_cfg(REG_SILENT_LIMIT, 16'(sil));
        add_cfg(REG_ARB_ENABLE, 16'(arb));
        gen_count = cnt;
        gen_self  = self_idx;
    endtask

    task automatic add_random_setting();
        int cnt;
        int tmo;
        int sil;
        case ($urandom_range(9))
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 16;
            default: cnt = $urandom_range(2, 16);
        endcase
        tmo = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 6);
        case ($urandom_range(5))
            0: sil = 0;
            1: sil = 65535;
            default: sil = $urandom_range(0, 6);
        endcase
        add_setting(cnt, $urandom_range(15), tmo, sil, 1'($urandom_range(1)));
    endtask

    // Mostly heartbeats and ticks so members drift in and out of liveness
    task automatic add_random_items(int num);
        int          pick;
        logic [1:0]  fn;
        logic [3:0]  nd;
        logic [15:0] gs;
        for (int k = 0; k < num; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)      fn = FUNC_HEARTBEAT;
            else if (pick < 70) fn = FUNC_TICK;
            else if (pick < 90) fn = FUNC_EVALUATE;
            else                fn = FUNC_FORGET;
            if (gen_count != 0 && $urandom_range(9) != 0)
                nd = 4'($urandom_range(gen_count - 1));
            else
                nd = 4'($urandom_range(15));
            case ($urandom_range(2))
                0: gs = 16'($urandom());
                1: gs = 16'hFFFF;
                default: gs = (16'($urandom()) & (16'hFFFF << gen_self))
                              | (16'h0001 << gen_self);
            endcase
            add_req(fn, nd, gs);
        end
    endtask

    task automatic add_random_phase(int idle, int num);
        phase_idle = idle;
        for (int done = 0; done < num; done += 45) begin
            if (done != 0)
                add_random_setting();
            add_random_items(45);
        end
    endtask

    // Driver: presents queued requests and register writes at the falling edge
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (have_job && (req_taken || cfg_taken))
                have_job = 1'b0;
            if (!have_job && job_queue.size() != 0) begin
                cur_job  = job_queue.pop_front();
                have_job = 1'b1;
            end
            if (!have_job) begin
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (!cur_job.is_cfg) begin
                start       <= ($urandom_range(99) >= cur_job.idle_pct);
                i_req       <= cur_job.req;
                i_cfg_valid <= 1'b0;
            end else begin
                // register writes only once the block is idle and drained
                start       <= 1'b0;
                i_cfg_index <= cur_job.reg_idx;
                i_cfg_data  <= cur_job.reg_data;
                i_cfg_valid <= i_cfg_valid || (!busy && expected_res.size() == 0);
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each result strobe
    always @(posedge i_clk) begin
        t_res want;
        req_taken <= i_rst_n && start && !busy;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (expected_res.size() == 0) begin
                    flag_error("result strobe with no request outstanding");
                end else begin
                    want = expected_res.pop_front();
                    if (o_res.live_mask !== want.live_mask)
                        flag_error($sformatf("live_mask %h, want %h",
                                             o_res.live_mask, want.live_mask));
                    if (o_res.ping_mask !== want.ping_mask)
                        flag_error($sformatf("ping_mask %h, want %h",
                                             o_res.ping_mask, want.ping_mask));
                    if (o_res.quorum !== want.quorum)
                        flag_error($sformatf("quorum %b, want %b",
                                             o_res.quorum, want.quorum));
                    if (o_res.is_leader !== want.is_leader)
                        flag_error($sformatf("is_leader %b, want %b",
                                             o_res.is_leader, want.is_leader));
                    if (o_res.leader_index !== want.leader_index)
                        flag_error($sformatf("leader_index %0d, want %0d",
                                             o_res.leader_index, want.leader_index));
                    if (o_res.send_view !== want.send_view)
                        flag_error($sformatf("send_view %b, want %b",
                                             o_res.send_view, want.send_view));
                    if (o_res.deliver_view !== want.deliver_view)
                        flag_error($sformatf("deliver_view %b, want %b",
                                             o_res.deliver_view, want.deliver_view));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_cfg(i_cfg_index, i_cfg_data);
            if (start && !busy)
                expected_res.push_back(liveness_step(i_req));
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_state();

        // Directed: empty group straight after reset, out of range heartbeat
        phase_idle = 0;
        gen_count  = 0;
        add_req(FUNC_EVALUATE, 4'd0, 16'hFFFF);
        add_req(FUNC_HEARTBEAT, 4'd0, 16'hFFFF);
        add_req(FUNC_TICK, 4'd15, 16'h0000);

        // Full group, self at the top, short timeouts
        add_setting(16, 15, 3, 2, 1'b0);
        add_req(FUNC_EVALUATE, 4'd0, 16'h0000);
        add_req(FUNC_HEARTBEAT, 4'd0, 16'h0000);
        add_req(FUNC_HEARTBEAT, 4'd15, 16'h0000);
        add_req(FUNC_HEARTBEAT, 4'd7, 16'h0000);
        add_req(FUNC_TICK, 4'd0, 16'hFFFF);
        add_req(FUNC_EVALUATE, 4'd0, 16'h8081);
        add_req(FUNC_TICK, 4'd0, 16'h8080);
        add_req(FUNC_TICK, 4'd0, 16'h8080);
        add_req(FUNC_EVALUATE, 4'd0, 16'h8000);
        add_req(FUNC_FORGET, 4'd7, 16'hFFFF);
        add_req(FUNC_EVALUATE, 4'd0, 16'hFFFF);

        // Self outside the group, global bits above the group size
        add_setting(3, 9, 1, 0, 1'b1);
        add_req(FUNC_HEARTBEAT, 4'd15, 16'hFFFF);
        add_req(FUNC_HEARTBEAT, 4'd1, 16'hFFFF);
        add_req(FUNC_EVALUATE, 4'd0, 16'hFFFF);
        add_req(FUNC_TICK, 4'd0, 16'h0002);
        add_req(FUNC_EVALUATE, 4'd0, 16'h0000);

        // Two-member group kept in quorum by the arbitrator; local view bits above n kept
        add_setting(2, 0, 2, 1, 1'b1);
        add_req(FUNC_EVALUATE, 4'd0, 16'h0003);
        add_req(FUNC_HEARTBEAT, 4'd1, 16'h0003);
        add_req(FUNC_EVALUATE, 4'd0, 16'h0001);

        // Random phases, the first two opened with an extreme setting, the last with a random one
        add_setting(16, 0, 1, 0, 1'b0);
        add_random_phase(23, 270);
        add_setting(0, 15, 65535, 65535, 1'b1);
        add_random_phase(87, 270);
        add_random_setting();
        add_random_phase(0, 270);

        // Reset held from time zero, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        while (job_queue.size() != 0 || have_job || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/nlqm_pkg.sv
rtl/nlqm_cell.sv
rtl/node_liveness_quorum_monitor.sv
dv/tb_top.sv
